[rtl/v3a_pkg.sv]
// shared constants, opcodes, lane status type and saturation helper
// for the three-component vector alu; no dependencies
package v3a_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int DATA_BITS = 32;
    localparam int SAT_BITS  = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;
    localparam int PROD_BITS = 2 * DATA_BITS;
    localparam int WIDE_BITS = PROD_BITS + 2;
    localparam int DIV_N     = DATA_BITS + FRAC_BITS;
    localparam int ROOT_BITS = DATA_BITS;
    localparam int OP_BITS   = 5;
    localparam int LANES     = 3;
    localparam int IN_BITS   = ((7 * DATA_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = ((4 * DATA_BITS + 2 + 7) / 8) * 8;

    localparam logic [DATA_BITS-1:0] SAT_HI =
        DATA_BITS'((65'(1) << (SAT_BITS - 1)) - 65'(1));
    localparam logic [DATA_BITS-1:0] SAT_LO = ~SAT_HI;

    localparam logic [OP_BITS-1:0] OP_ADD    = 5'd0;
    localparam logic [OP_BITS-1:0] OP_SUB    = 5'd1;
    localparam logic [OP_BITS-1:0] OP_MUL    = 5'd2;
    localparam logic [OP_BITS-1:0] OP_DIV    = 5'd3;
    localparam logic [OP_BITS-1:0] OP_SCALE  = 5'd4;
    localparam logic [OP_BITS-1:0] OP_DIVS   = 5'd5;
    localparam logic [OP_BITS-1:0] OP_NEG    = 5'd6;
    localparam logic [OP_BITS-1:0] OP_DOT    = 5'd7;
    localparam logic [OP_BITS-1:0] OP_CROSS  = 5'd8;
    localparam logic [OP_BITS-1:0] OP_LENGTH = 5'd9;
    localparam logic [OP_BITS-1:0] OP_NORM   = 5'd10;
    localparam logic [OP_BITS-1:0] OP_EQ     = 5'd11;
    localparam logic [OP_BITS-1:0] OP_NE     = 5'd12;
    localparam logic [OP_BITS-1:0] OP_GT     = 5'd13;
    localparam logic [OP_BITS-1:0] OP_GE     = 5'd14;
    localparam logic [OP_BITS-1:0] OP_LT     = 5'd15;
    localparam logic [OP_BITS-1:0] OP_LE     = 5'd16;

    typedef struct packed {
        logic [DATA_BITS-1:0] res;
        logic                 eq;
        logic                 lt;
    } t_lane;

    function automatic logic [DATA_BITS-1:0] sat_word(input logic signed [WIDE_BITS-1:0] v);
        logic signed [WIDE_BITS-1:0] hi;
        logic signed [WIDE_BITS-1:0] lo;
        hi = WIDE_BITS'($signed(SAT_HI));
        lo = WIDE_BITS'($signed(SAT_LO));
        if (v > hi) begin
            return SAT_HI;
        end
        if (v < lo) begin
            return SAT_LO;
        end
        return v[DATA_BITS-1:0];
    endfunction

endpackage

[rtl/v3a_lane.sv]
// one component lane: operand select and products, then the per-lane
// results (add, sub, negate, multiply, scale, cross) and compare bits; uses v3a_pkg
module v3a_lane (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [v3a_pkg::OP_BITS-1:0]            i_op,
    input  logic signed [v3a_pkg::DATA_BITS-1:0]   i_a,
    input  logic signed [v3a_pkg::DATA_BITS-1:0]   i_b,
    input  logic signed [v3a_pkg::DATA_BITS-1:0]   i_s,
    input  logic signed [v3a_pkg::DATA_BITS-1:0]   i_ca,
    input  logic signed [v3a_pkg::DATA_BITS-1:0]   i_cb,
    input  logic signed [v3a_pkg::DATA_BITS-1:0]   i_da,
    input  logic signed [v3a_pkg::DATA_BITS-1:0]   i_db,
    output logic signed [v3a_pkg::PROD_BITS-1:0]   o_p0,
    output logic signed [v3a_pkg::DATA_BITS-1:0]   o_a,
    output logic signed [v3a_pkg::DATA_BITS-1:0]   o_b,
    output v3a_pkg::t_lane                         o_res
);

    logic signed [v3a_pkg::DATA_BITS-1:0] n_x;
    logic signed [v3a_pkg::DATA_BITS-1:0] n_y;
    logic signed [v3a_pkg::PROD_BITS-1:0] r_p0;
    logic signed [v3a_pkg::PROD_BITS-1:0] r_p1;
    logic signed [v3a_pkg::DATA_BITS-1:0] r_a;
    logic signed [v3a_pkg::DATA_BITS-1:0] r_b;
    logic [v3a_pkg::OP_BITS-1:0]          r_op;
    logic signed [v3a_pkg::DATA_BITS:0]   w_add;
    logic signed [v3a_pkg::DATA_BITS:0]   w_sub;
    logic signed [v3a_pkg::DATA_BITS:0]   w_neg;
    logic signed [v3a_pkg::PROD_BITS:0]   w_crs;
    v3a_pkg::t_lane                       n_res;
    v3a_pkg::t_lane                       r_res;

    always_comb begin
        n_x = i_a;
        n_y = i_b;
        case (i_op)
            v3a_pkg::OP_CROSS: begin
                n_x = i_ca;
                n_y = i_cb;
            end
            v3a_pkg::OP_SCALE: begin
                n_y = i_s;
            end
            v3a_pkg::OP_LENGTH, v3a_pkg::OP_NORM: begin
                n_y = i_a;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= n_x * n_y;
            r_p1 <= i_da * i_db;
            r_a  <= i_a;
            r_b  <= i_b;
            r_op <= i_op;
        end
    end

    assign w_add = (v3a_pkg::DATA_BITS + 1)'(r_a) + (v3a_pkg::DATA_BITS + 1)'(r_b);
    assign w_sub = (v3a_pkg::DATA_BITS + 1)'(r_a) - (v3a_pkg::DATA_BITS + 1)'(r_b);
    assign w_neg = -((v3a_pkg::DATA_BITS + 1)'(r_a));
    assign w_crs = (v3a_pkg::PROD_BITS + 1)'(r_p0) - (v3a_pkg::PROD_BITS + 1)'(r_p1);

    always_comb begin
        n_res.eq  = (r_a == r_b);
        n_res.lt  = (r_a < r_b);
        n_res.res = '0;
        case (r_op)
            v3a_pkg::OP_ADD: begin
                n_res.res = v3a_pkg::sat_word(v3a_pkg::WIDE_BITS'(w_add));
            end
            v3a_pkg::OP_SUB: begin
                n_res.res = v3a_pkg::sat_word(v3a_pkg::WIDE_BITS'(w_sub));
            end
            v3a_pkg::OP_NEG: begin
                n_res.res = v3a_pkg::sat_word(v3a_pkg::WIDE_BITS'(w_neg));
            end
            v3a_pkg::OP_MUL, v3a_pkg::OP_SCALE: begin
                n_res.res = v3a_pkg::sat_word(
                    v3a_pkg::WIDE_BITS'(r_p0 >>> v3a_pkg::FRAC_BITS));
            end
            v3a_pkg::OP_CROSS: begin
                n_res.res = v3a_pkg::sat_word(
                    v3a_pkg::WIDE_BITS'(w_crs >>> v3a_pkg::FRAC_BITS));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_p0  = r_p0;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_res = r_res;

endmodule

[rtl/v3a_sqrt.sv]
// pipelined integer square root, one root bit per stage, floor result
// uses v3a_pkg
module v3a_sqrt (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [v3a_pkg::PROD_BITS-1:0]       i_val,
    output logic [v3a_pkg::ROOT_BITS-1:0]       o_root
);

    localparam int RB = v3a_pkg::ROOT_BITS;
    localparam int VB = v3a_pkg::PROD_BITS;

    logic [VB-1:0]   r_v    [RB];
    logic [RB+1:0]   r_rem  [RB];
    logic [RB-1:0]   r_root [RB];

    for (genvar g = 0; g < RB; g++) begin : g_stage
        logic [VB-1:0] w_v;
        logic [RB+1:0] w_rem;
        logic [RB-1:0] w_root;
        logic [RB+3:0] w_t;
        logic [RB+3:0] w_trial;
        logic          w_ge;

        if (g == 0) begin : g_first
            assign w_v    = i_val;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_v    = r_v[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
        end

        assign w_t     = {w_rem, w_v[VB-1 -: 2]};
        assign w_trial = (RB + 4)'({w_root, 2'b01});
        assign w_ge    = (w_t >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g]    <= w_v << 2;
                r_rem[g]  <= (RB + 2)'(w_ge ? (w_t - w_trial) : w_t);
                r_root[g] <= {w_root[RB-2:0], w_ge};
            end
        end
    end

    assign o_root = r_root[RB-1];

endmodule

[rtl/v3a_div.sv]
// pipelined restoring divider on magnitudes, one quotient bit per stage,
// with sign, zero-divisor handling and saturation at the end; uses v3a_pkg
module v3a_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [v3a_pkg::DIV_N-1:0]           i_num,
    input  logic [v3a_pkg::DATA_BITS-1:0]       i_den,
    input  logic                                i_neg,
    input  logic                                i_num_pos,
    input  logic                                i_num_neg,
    output logic [v3a_pkg::DATA_BITS-1:0]       o_q,
    output logic                                o_dz
);

    localparam int N  = v3a_pkg::DIV_N;
    localparam int DB = v3a_pkg::DATA_BITS;

    logic [DB-1:0] r_rem [N];
    logic [N-1:0]  r_nq  [N];
    logic [DB-1:0] r_den [N];
    logic          r_neg [N];
    logic          r_pos [N];
    logic          r_nn  [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [DB-1:0] w_rem;
        logic [N-1:0]  w_nq;
        logic [DB-1:0] w_den;
        logic          w_neg;
        logic          w_pos;
        logic          w_nn;
        logic [DB:0]   w_t;
        logic [DB:0]   w_d;
        logic          w_ge;

        if (g == 0) begin : g_first
            assign w_rem = '0;
            assign w_nq  = i_num;
            assign w_den = i_den;
            assign w_neg = i_neg;
            assign w_pos = i_num_pos;
            assign w_nn  = i_num_neg;
        end else begin : g_next
            assign w_rem = r_rem[g-1];
            assign w_nq  = r_nq[g-1];
            assign w_den = r_den[g-1];
            assign w_neg = r_neg[g-1];
            assign w_pos = r_pos[g-1];
            assign w_nn  = r_nn[g-1];
        end

        assign w_t  = {w_rem, w_nq[N-1]};
        assign w_d  = {1'b0, w_den};
        assign w_ge = (w_t >= w_d);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= DB'(w_ge ? (w_t - w_d) : w_t);
                r_nq[g]  <= {w_nq[N-2:0], w_ge};
                r_den[g] <= w_den;
                r_neg[g] <= w_neg;
                r_pos[g] <= w_pos;
                r_nn[g]  <= w_nn;
            end
        end
    end

    logic signed [N:0] w_qs;

    assign w_qs = r_neg[N-1] ? -$signed({1'b0, r_nq[N-1]}) : $signed({1'b0, r_nq[N-1]});
    assign o_dz = (r_den[N-1] == '0);

    always_comb begin
        if (o_dz) begin
            if (r_pos[N-1]) begin
                o_q = v3a_pkg::SAT_HI;
            end else if (r_nn[N-1]) begin
                o_q = v3a_pkg::SAT_LO;
            end else begin
                o_q = '0;
            end
        end else begin
            o_q = v3a_pkg::sat_word(v3a_pkg::WIDE_BITS'(w_qs));
        end
    end

endmodule

[rtl/vector3_alu.sv]
// throughput: one beat per cycle while the output is not stalled;
// set by the 32-stage root pipeline and the 48-stage divide pipeline
// of each lane, all fully pipelined
// the whole pipeline holds only while an output beat waits unaccepted
// reset (synchronous, active low) clears the valid bits, data is not reset
module vector3_alu (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
    input  logic [v3a_pkg::IN_BITS-1:0]         s_axis_tdata,
    // opcode
    input  logic [v3a_pkg::OP_BITS-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // r_x, r_y, r_z, scalar_out, compare_true, divide_by_zero, zero pad
    output logic [v3a_pkg::OUT_BITS-1:0]        m_axis_tdata
);

    localparam int DB = v3a_pkg::DATA_BITS;
    localparam int NL = v3a_pkg::LANES;
    localparam int SQ = v3a_pkg::ROOT_BITS;
    localparam int DN = v3a_pkg::DIV_N;

    typedef struct packed {
        logic [v3a_pkg::OP_BITS-1:0] op;
        logic [NL-1:0][DB-1:0]       res;
        logic [DB-1:0]               scalar;
        logic                        cmp;
        logic [NL-1:0][DB-1:0]       num;
        logic [NL-1:0][DB-1:0]       den;
    } t_side1;

    typedef struct packed {
        logic [v3a_pkg::OP_BITS-1:0] op;
        logic [NL-1:0][DB-1:0]       res;
        logic [DB-1:0]               scalar;
        logic                        cmp;
    } t_side2;

    logic w_en;
    logic r_out_valid;
    logic [v3a_pkg::OUT_BITS-1:0] r_out_data;
    logic [v3a_pkg::OUT_BITS-1:0] n_out_data;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    logic signed [DB-1:0] w_a [NL];
    logic signed [DB-1:0] w_b [NL];
    logic signed [DB-1:0] w_s;

    assign w_s = s_axis_tdata[6*DB +: DB];

    logic signed [v3a_pkg::PROD_BITS-1:0] w_p0 [NL];
    logic signed [DB-1:0]                 w_la [NL];
    logic signed [DB-1:0]                 w_lb [NL];
    v3a_pkg::t_lane                       w_lres [NL];

    for (genvar i = 0; i < NL; i++) begin : g_lane
        localparam int J = (i + 1) % NL;
        localparam int K = (i + 2) % NL;

        assign w_a[i] = s_axis_tdata[i*DB +: DB];
        assign w_b[i] = s_axis_tdata[(i+NL)*DB +: DB];

        v3a_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_op  (s_axis_tuser),
            .i_a   (w_a[i]),
            .i_b   (w_b[i]),
            .i_s   (w_s),
            .i_ca  (w_a[J]),
            .i_cb  (w_b[K]),
            .i_da  (w_a[K]),
            .i_db  (w_b[J]),
            .o_p0  (w_p0[i]),
            .o_a   (w_la[i]),
            .o_b   (w_lb[i]),
            .o_res (w_lres[i])
        );
    end

    // stage 1 side registers
    logic [v3a_pkg::OP_BITS-1:0] r_op1;
    logic signed [DB-1:0]        r_s1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op1 <= s_axis_tuser;
            r_s1  <= w_s;
        end
    end

    // stage 2 merge of the lane products
    logic signed [v3a_pkg::WIDE_BITS-1:0] w_sum;
    logic [v3a_pkg::OP_BITS-1:0]          r_op2;
    logic [DB-1:0]                        r_dot;
    logic [v3a_pkg::PROD_BITS-1:0]        r_sq;
    logic [NL-1:0][DB-1:0]                r_num;
    logic [NL-1:0][DB-1:0]                r_den;

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < NL; i++) begin
            w_sum = w_sum + v3a_pkg::WIDE_BITS'(w_p0[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op2 <= r_op1;
            r_dot <= (r_op1 == v3a_pkg::OP_DOT) ?
                     v3a_pkg::sat_word(w_sum >>> v3a_pkg::FRAC_BITS) : '0;
            r_sq  <= w_sum[v3a_pkg::PROD_BITS-1:0];
            for (int i = 0; i < NL; i++) begin
                r_num[i] <= w_la[i];
                r_den[i] <= (r_op1 == v3a_pkg::OP_DIVS) ? r_s1 : w_lb[i];
            end
        end
    end

    // compare and side data into the root pipeline
    logic   w_eq_all;
    logic   w_any_eq;
    logic   w_any_lt;
    logic   w_any_gt;
    t_side1 n_sd1;

    always_comb begin
        w_eq_all = 1'b1;
        w_any_eq = 1'b0;
        w_any_lt = 1'b0;
        w_any_gt = 1'b0;
        for (int i = 0; i < NL; i++) begin
            w_eq_all = w_eq_all & w_lres[i].eq;
            w_any_eq = w_any_eq | w_lres[i].eq;
            w_any_lt = w_any_lt | w_lres[i].lt;
            w_any_gt = w_any_gt | (!w_lres[i].eq && !w_lres[i].lt);
        end
        n_sd1.op     = r_op2;
        n_sd1.scalar = r_dot;
        n_sd1.num    = r_num;
        n_sd1.den    = r_den;
        for (int i = 0; i < NL; i++) begin
            n_sd1.res[i] = w_lres[i].res;
        end
        case (r_op2)
            v3a_pkg::OP_EQ: n_sd1.cmp = w_eq_all;
            v3a_pkg::OP_NE: n_sd1.cmp = !w_eq_all;
            v3a_pkg::OP_GT: n_sd1.cmp = w_any_gt;
            v3a_pkg::OP_GE: n_sd1.cmp = w_any_gt || w_any_eq;
            v3a_pkg::OP_LT: n_sd1.cmp = w_any_lt;
            v3a_pkg::OP_LE: n_sd1.cmp = w_any_lt || w_any_eq;
            default:        n_sd1.cmp = 1'b0;
        endcase
    end

    logic [v3a_pkg::ROOT_BITS-1:0] w_root;
    t_side1                        r_sd1 [SQ];

    v3a_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_sq),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd1[0] <= n_sd1;
            for (int k = 1; k < SQ; k++) begin
                r_sd1[k] <= r_sd1[k-1];
            end
        end
    end

    // divider entry
    t_side1 w_d1;
    t_side2 n_sd2;
    t_side2 r_sd2 [DN];
    logic   w_is_norm;

    assign w_d1      = r_sd1[SQ-1];
    assign w_is_norm = (w_d1.op == v3a_pkg::OP_NORM);

    always_comb begin
        n_sd2.op     = w_d1.op;
        n_sd2.res    = w_d1.res;
        n_sd2.cmp    = w_d1.cmp;
        n_sd2.scalar = (w_d1.op == v3a_pkg::OP_LENGTH) ?
                       v3a_pkg::sat_word(v3a_pkg::WIDE_BITS'(w_root)) : w_d1.scalar;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd2[0] <= n_sd2;
            for (int k = 1; k < DN; k++) begin
                r_sd2[k] <= r_sd2[k-1];
            end
        end
    end

    logic [DB-1:0] w_q  [NL];
    logic          w_dz [NL];

    for (genvar i = 0; i < NL; i++) begin : g_div
        logic signed [DB-1:0] w_n;
        logic signed [DB-1:0] w_d;
        logic [DB-1:0]        w_nmag;
        logic [DB-1:0]        w_dmag;

        assign w_n    = w_d1.num[i];
        assign w_d    = w_d1.den[i];
        assign w_nmag = w_n[DB-1] ? DB'(-w_n) : DB'(w_n);
        assign w_dmag = w_is_norm ? w_root : (w_d[DB-1] ? DB'(-w_d) : DB'(w_d));

        v3a_div u_div (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_num     (DN'(w_nmag) << v3a_pkg::FRAC_BITS),
            .i_den     (w_dmag),
            .i_neg     (w_n[DB-1] ^ (!w_is_norm && w_d[DB-1])),
            .i_num_pos (!w_n[DB-1] && (w_n != '0)),
            .i_num_neg (w_n[DB-1]),
            .o_q       (w_q[i]),
            .o_dz      (w_dz[i])
        );
    end

    // output select
    t_side2 w_d2;
    logic   w_div_op;

    assign w_d2     = r_sd2[DN-1];
    assign w_div_op = (w_d2.op == v3a_pkg::OP_DIV) || (w_d2.op == v3a_pkg::OP_DIVS) ||
                      (w_d2.op == v3a_pkg::OP_NORM);

    always_comb begin
        n_out_data = '0;
        for (int i = 0; i < NL; i++) begin
            n_out_data[i*DB +: DB] = w_div_op ? w_q[i] : w_d2.res[i];
        end
        n_out_data[NL*DB +: DB] = w_d2.scalar;
        n_out_data[(NL+1)*DB]   = w_d2.cmp;
        n_out_data[(NL+1)*DB+1] = w_div_op && (w_dz[0] || w_dz[1] || w_dz[2]);
    end

    // beat valid tracking
    logic       r_v1;
    logic       r_v2;
    logic [SQ-1:0] r_vs;
    logic [DN-1:0] r_vd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_vs        <= '0;
            r_vd        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= s_axis_tvalid;
            r_v2        <= r_v1;
            r_vs        <= {r_vs[SQ-2:0], r_v2};
            r_vd        <= {r_vd[DN-2:0], r_vs[SQ-1]};
            r_out_valid <= r_vd[DN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

[rtl/v3a_chk.sv]
// port-level checker for vector3_alu, bound to the top level
// uses v3a_pkg for the port widths
module v3a_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [v3a_pkg::IN_BITS-1:0]         s_axis_tdata,
    input logic [v3a_pkg::OP_BITS-1:0]         s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [v3a_pkg::OUT_BITS-1:0]        m_axis_tdata
);

    localparam int CB = 4 * v3a_pkg::DATA_BITS;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[CB]) |-> (m_axis_tdata[CB-1:0] == '0))
        else $error("compare beat carries numeric data");

    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[CB] && m_axis_tdata[CB+1]))
        else $error("compare and divide-by-zero flags both set");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input held off without an output stall");

endmodule

bind vector3_alu v3a_chk u_v3a_chk (.*);
